/* hw/rtl/quadratic_real_roots_macros.svh */
// ----------------------------------------------------------------------------
// quadratic_real_roots_macros
// Assertion macros shared by the quadratic root solver RTL.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_REAL_ROOTS_MACROS_SVH
`define QUADRATIC_REAL_ROOTS_MACROS_SVH

// implication checked on every rising edge outside reset
`define QRR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// plain condition checked on every rising edge outside reset
`define QRR_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

/* hw/rtl/qrr_pkg.sv */
// ----------------------------------------------------------------------------
// qrr_pkg
// Widths, status codes and transfer types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrr_pkg;

  // fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 32;

  // divider: dividend is the magnitude shifted up by the fraction bits
  localparam int NUM_W   = Q_W + FRAC_BITS;
  localparam int DIV_LAT = NUM_W;
  localparam int REM_W   = Q_W + 1;

  // discriminant and square root
  localparam int D4_W     = 2 * Q_W + 2;
  localparam int SQ_W     = 2 * Q_W;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int SQ_REM_W = ROOT_W + 3;

  // accept edge to result transfer edge
  localparam int LATENCY = DIV_LAT + ROOT_W + 5;

  typedef enum logic [2:0] {
    ST_TWO_ROOTS = 3'd0,
    ST_LINEAR    = 3'd1,
    ST_NEG_DISC  = 3'd2,
    ST_A_B_ZERO  = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [Q_W-1:0] coeff_a;
    logic signed [Q_W-1:0] coeff_b;
    logic signed [Q_W-1:0] coeff_c;
  } coeffs_t;

  typedef struct packed {
    logic signed [Q_W-1:0] root_plus;
    logic signed [Q_W-1:0] root_minus;
    logic [2:0]            status;
  } roots_t;

  // sideband that rides along the dividers
  typedef struct packed {
    logic lin;
    logic ab_zero;
    logic neg1;
    logic neg2;
  } div_side_t;

  // sideband after normalization
  typedef struct packed {
    status_t               kind;
    logic signed [Q_W-1:0] lin_root;
    logic signed [Q_W-1:0] bn;
    logic signed [Q_W-1:0] cn;
  } norm_side_t;

  // sideband that rides along the square root
  typedef struct packed {
    status_t               kind;
    logic signed [Q_W-1:0] lin_root;
    logic signed [Q_W-1:0] bn;
  } root_side_t;

  // magnitude of a two's complement word
  function automatic logic [Q_W-1:0] mag(input logic [Q_W-1:0] x);
    return x[Q_W-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

/* hw/rtl/quadratic_real_roots.sv */
// ----------------------------------------------------------------------------
// quadratic_real_roots
// Real roots of a*x^2 + b*x + c = 0 in signed Q16.16 with status code.
// A start transfer passes the input register, the bit-per-stage divider,
// the normalize, square and discriminant registers, the pipelined square
// root and the output register. Throughput: one item per cycle, busy only
// during reset. Reset clears the valid bits; results are never held off.
// ----------------------------------------------------------------------------
`include "quadratic_real_roots_macros.svh"

module quadratic_real_roots (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  qrr_pkg::coeffs_t coeffs,
  output logic             busy,
  output logic             done,
  output qrr_pkg::roots_t  result
);
  import qrr_pkg::*;

  logic accept;

  // input stage
  logic       prep_v;
  div_side_t  prep_side;
  logic [Q_W-1:0] num1, den1, num2, den2;

  // divider stages
  logic       dv [1:DIV_LAT];
  div_side_t  ds [1:DIV_LAT];
  logic [NUM_W-1:0] quo1, quo2;

  // normalize, square, discriminant stages
  logic       p1_v, p2_v, p3_v;
  norm_side_t p1;
  root_side_t p2, p3;
  logic signed [2*Q_W-1:0] sq;
  logic signed [D4_W-1:0]  cn4;
  logic signed [D4_W-1:0]  d4_next;
  logic [SQ_W-1:0]         rad;

  // square root stages
  logic       sv [1:ROOT_W];
  root_side_t ss [1:ROOT_W];
  logic [ROOT_W-1:0] s_root;

  assign busy   = rst;
  assign accept = start & ~busy;

  // quotient magnitude to signed word, with range flag in the top bit
  function automatic logic [Q_W:0] to_signed(input logic [NUM_W-1:0] m,
                                             input logic neg);
    logic           hi;
    logic           ovf;
    logic [Q_W-1:0] val;
    hi  = |m[NUM_W-1:Q_W];
    ovf = hi | (neg ? (m[Q_W-1] & (|m[Q_W-2:0])) : m[Q_W-1]);
    val = neg ? (~m[Q_W-1:0] + 1'b1) : m[Q_W-1:0];
    return {ovf, val};
  endfunction

  // halve with floor and saturate, range flag in the top bit
  function automatic logic [Q_W:0] half_sat(input logic signed [Q_W+1:0] v);
    logic signed [Q_W:0] h;
    logic                ovf;
    logic [Q_W-1:0]      val;
    h   = v[Q_W+1:1];
    ovf = (h[Q_W] != h[Q_W-1]);
    val = ovf ? (h[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}})
              : h[Q_W-1:0];
    return {ovf, val};
  endfunction

  // input valid
  always_ff @(posedge clk) begin
    if (rst) begin
      prep_v <= 1'b0;
    end else begin
      prep_v <= accept;
    end
  end

  // route magnitudes to the dividers: c/b when a is zero, else b/a and c/a
  always_ff @(posedge clk) begin
    logic lin;
    lin = (coeffs.coeff_a == '0);
    num1 <= lin ? mag(coeffs.coeff_c) : mag(coeffs.coeff_b);
    den1 <= lin ? mag(coeffs.coeff_b) : mag(coeffs.coeff_a);
    num2 <= mag(coeffs.coeff_c);
    den2 <= mag(coeffs.coeff_a);
    prep_side.lin     <= lin;
    prep_side.ab_zero <= lin & (coeffs.coeff_b == '0);
    prep_side.neg1    <= lin ? ~(coeffs.coeff_c[Q_W-1] ^ coeffs.coeff_b[Q_W-1])
                             : (coeffs.coeff_b[Q_W-1] ^ coeffs.coeff_a[Q_W-1]);
    prep_side.neg2    <= coeffs.coeff_c[Q_W-1] ^ coeffs.coeff_a[Q_W-1];
  end

  qrr_div u_div_b (
    .clk (clk),
    .num (num1),
    .den (den1),
    .quo (quo1)
  );

  qrr_div u_div_c (
    .clk (clk),
    .num (num2),
    .den (den2),
    .quo (quo2)
  );

  // sideband alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= DIV_LAT; i++) dv[i] <= 1'b0;
    end else begin
      dv[1] <= prep_v;
      for (int i = 2; i <= DIV_LAT; i++) dv[i] <= dv[i-1];
    end
  end

  always_ff @(posedge clk) begin
    ds[1] <= prep_side;
    for (int i = 2; i <= DIV_LAT; i++) ds[i] <= ds[i-1];
  end

  // normalize: sign the quotients, classify the item
  always_ff @(posedge clk) begin
    logic [Q_W:0] q1;
    logic [Q_W:0] q2;
    q1 = to_signed(quo1, ds[DIV_LAT].neg1);
    q2 = to_signed(quo2, ds[DIV_LAT].neg2);
    p1.bn <= q1[Q_W-1:0];
    p1.cn <= q2[Q_W-1:0];
    if (ds[DIV_LAT].ab_zero) begin
      p1.kind     <= ST_A_B_ZERO;
      p1.lin_root <= '0;
    end else if (ds[DIV_LAT].lin) begin
      p1.kind     <= q1[Q_W] ? ST_OVERFLOW : ST_LINEAR;
      p1.lin_root <= q1[Q_W] ? (ds[DIV_LAT].neg1 ? {1'b1, {(Q_W-1){1'b0}}}
                                                 : {1'b0, {(Q_W-1){1'b1}}})
                             : q1[Q_W-1:0];
    end else begin
      p1.kind     <= (q1[Q_W] | q2[Q_W]) ? ST_OVERFLOW : ST_TWO_ROOTS;
      p1.lin_root <= '0;
    end
  end

  // square bn, scale cn by four and the fraction
  always_ff @(posedge clk) begin
    sq  <= p1.bn * p1.bn;
    cn4 <= {{(D4_W-Q_W){p1.cn[Q_W-1]}}, p1.cn} <<< (FRAC_BITS + 2);
    p2.kind     <= p1.kind;
    p2.lin_root <= p1.lin_root;
    p2.bn       <= p1.bn;
  end

  // discriminant times four
  assign d4_next = {{(D4_W-2*Q_W){1'b0}}, sq} - cn4;

  always_ff @(posedge clk) begin
    rad         <= d4_next[SQ_W-1:0];
    p3.lin_root <= p2.lin_root;
    p3.bn       <= p2.bn;
    if (p2.kind == ST_TWO_ROOTS && d4_next[D4_W-1]) begin
      p3.kind <= ST_NEG_DISC;
    end else begin
      p3.kind <= p2.kind;
    end
  end

  // stage valids through normalize, square and discriminant
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else begin
      p1_v <= dv[DIV_LAT];
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  qrr_sqrt u_sqrt (
    .clk  (clk),
    .rad  (rad),
    .root (s_root)
  );

  // sideband alongside the square root
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= ROOT_W; i++) sv[i] <= 1'b0;
    end else begin
      sv[1] <= p3_v;
      for (int i = 2; i <= ROOT_W; i++) sv[i] <= sv[i-1];
    end
  end

  always_ff @(posedge clk) begin
    ss[1] <= p3;
    for (int i = 2; i <= ROOT_W; i++) ss[i] <= ss[i-1];
  end

  // roots from -bn and twice the square root, then the result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sv[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [Q_W+1:0] nb;
    logic [Q_W:0]          rp;
    logic [Q_W:0]          rm;
    nb = -{{2{ss[ROOT_W].bn[Q_W-1]}}, ss[ROOT_W].bn};
    rp = half_sat(nb + {{(Q_W+2-ROOT_W){1'b0}}, s_root});
    rm = half_sat(nb - {{(Q_W+2-ROOT_W){1'b0}}, s_root});
    case (ss[ROOT_W].kind)
      ST_TWO_ROOTS: begin
        result.root_plus  <= rp[Q_W-1:0];
        result.root_minus <= rm[Q_W-1:0];
        result.status     <= (rp[Q_W] | rm[Q_W]) ? ST_OVERFLOW : ST_TWO_ROOTS;
      end
      default: begin
        result.root_plus  <= ss[ROOT_W].lin_root;
        result.root_minus <= ss[ROOT_W].lin_root;
        result.status     <= ss[ROOT_W].kind;
      end
    endcase
  end

  // checks
  `QRR_ASSERT_ALWAYS(a_latency, clk, rst, done == $past(start && !busy, LATENCY), "result strobe does not match accepted start")
  `QRR_ASSERT_IMP(a_order, clk, rst, done && result.status == ST_TWO_ROOTS, $signed(result.root_plus) >= $signed(result.root_minus), "plus root below minus root")
  `QRR_ASSERT_IMP(a_linear, clk, rst, done && result.status == ST_LINEAR, result.root_plus == result.root_minus, "linear roots differ")
  `QRR_ASSERT_IMP(a_zero, clk, rst, done && (result.status == ST_NEG_DISC || result.status == ST_A_B_ZERO), result.root_plus == '0 && result.root_minus == '0, "roots not cleared")

endmodule

/* hw/rtl/qrr_div.sv */
// ----------------------------------------------------------------------------
// qrr_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrr_div (
  input  logic                      clk,
  input  logic [qrr_pkg::Q_W-1:0]   num,
  input  logic [qrr_pkg::Q_W-1:0]   den,
  output logic [qrr_pkg::NUM_W-1:0] quo
);
  import qrr_pkg::*;

  // per-stage remainder, dividend/quotient shift word and divisor
  logic [REM_W-1:0] rem_s [1:DIV_LAT];
  logic [NUM_W-1:0] num_s [1:DIV_LAT];
  logic [Q_W-1:0]   den_s [1:DIV_LAT];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [Q_W-1:0]   den_in;
    logic [REM_W-1:0] trial;
    logic             fits;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = {num, {FRAC_BITS{1'b0}}};
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_s[i];
      assign num_in = num_s[i];
      assign den_in = den_s[i];
    end

    // bring down the next dividend bit and try the subtract
    always_comb begin
      trial = {rem_in[REM_W-2:0], num_in[NUM_W-1]};
      fits  = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk) begin
      rem_s[i+1] <= fits ? (trial - {1'b0, den_in}) : trial;
      num_s[i+1] <= {num_in[NUM_W-2:0], fits};
      den_s[i+1] <= den_in;
    end
  end

  assign quo = num_s[DIV_LAT];

endmodule

/* hw/rtl/qrr_sqrt.sv */
// ----------------------------------------------------------------------------
// qrr_sqrt
// Pipelined integer square root, floor result, one root bit per stage.
// ----------------------------------------------------------------------------
module qrr_sqrt (
  input  logic                       clk,
  input  logic [qrr_pkg::SQ_W-1:0]   rad,
  output logic [qrr_pkg::ROOT_W-1:0] root
);
  import qrr_pkg::*;

  logic [SQ_REM_W-1:0] rem_s  [1:ROOT_W];
  logic [ROOT_W-1:0]   root_s [1:ROOT_W];
  logic [SQ_W-1:0]     rad_s  [1:ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [SQ_REM_W-1:0] rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [SQ_W-1:0]     rad_in;
    logic [SQ_REM_W-1:0] cur;
    logic [SQ_REM_W-1:0] trial;
    logic                fits;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_s[i];
      assign root_in = root_s[i];
      assign rad_in  = rad_s[i];
    end

    // bring down two radicand bits, trial is 4*root + 1
    always_comb begin
      cur   = {rem_in[SQ_REM_W-3:0], rad_in[SQ_W-1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      fits  = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      rem_s[i+1]  <= fits ? (cur - trial) : cur;
      root_s[i+1] <= {root_in[ROOT_W-2:0], fits};
      rad_s[i+1]  <= {rad_in[SQ_W-3:0], 2'b00};
    end
  end

  assign root = root_s[ROOT_W];

endmodule

/* tb/quadratic_real_roots_tb.sv */
// ----------------------------------------------------------------------------
// quadratic_real_roots_tb
// Drives coefficient sets into the quadratic root solver with random gaps,
// predicts each root pair and status in fixed point, and checks every
// result against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadratic_real_roots_tb;
  import qrr_pkg::*;

  localparam int N_RANDOM  = 1030;
  localparam int MAX_CYCLE = 200000;

  // predicted roots, oldest first
  class roots_scoreboard;
    roots_t pending_roots[$];
    int     n_errors;

    function longint sat_q(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function bit out_q(longint v);
      return v > 64'sd2147483647 || v < -64'sd2147483648;
    endfunction

    function longint floor_half(longint v);
      if (v >= 0) return v / 2;
      return -((-v + 1) / 2);
    endfunction

    function longint int_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    // compute expected roots for one accepted coefficient set
    function void note_coeffs(coeffs_t cf);
      longint a, b, c, one, q, bn, cn, d4, s, r1, r2;
      roots_t rr;
      one = 64'sd1 <<< FRAC_BITS;
      a = longint'(cf.coeff_a);
      b = longint'(cf.coeff_b);
      c = longint'(cf.coeff_c);
      rr = '0;
      if (a == 0) begin
        if (b == 0) begin
          rr.status = ST_A_B_ZERO;
        end else begin
          q = (-c * one) / b;
          rr.root_plus = 32'(sat_q(q));
          rr.root_minus = 32'(sat_q(q));
          rr.status = out_q(q) ? ST_OVERFLOW : ST_LINEAR;
        end
      end else begin
        bn = (b * one) / a;
        cn = (c * one) / a;
        if (out_q(bn) || out_q(cn)) begin
          rr.status = ST_OVERFLOW;
        end else begin
          d4 = bn * bn - 4 * cn * one;
          if (d4 < 0) begin
            rr.status = ST_NEG_DISC;
          end else begin
            s = int_sqrt(d4);
            r1 = floor_half(-bn + s);
            r2 = floor_half(-bn - s);
            rr.root_plus = 32'(sat_q(r1));
            rr.root_minus = 32'(sat_q(r2));
            rr.status = (out_q(r1) || out_q(r2)) ? ST_OVERFLOW : ST_TWO_ROOTS;
          end
        end
      end
      pending_roots.push_back(rr);
    endfunction

    // compare one result transfer with the oldest prediction
    function void check_roots(roots_t got);
      roots_t exp_r;
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        n_errors++;
        return;
      end
      exp_r = pending_roots.pop_front();
      if (got.root_plus !== exp_r.root_plus) begin
        $display("%0t: root_plus expected %h actual %h", $time,
                 exp_r.root_plus, got.root_plus);
        n_errors++;
      end
      if (got.root_minus !== exp_r.root_minus) begin
        $display("%0t: root_minus expected %h actual %h", $time,
                 exp_r.root_minus, got.root_minus);
        n_errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time,
                 exp_r.status, got.status);
        n_errors++;
      end
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  coeffs_t coeffs;
  logic    busy;
  logic    done;
  roots_t  result;
  int      cycle_count;
  roots_scoreboard sb;

  quadratic_real_roots u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .coeffs (coeffs),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // note input transfers and check result transfers at the rising edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && start && !busy) sb.note_coeffs(coeffs);
    if (!rst && done) sb.check_roots(result);
    if (cycle_count > MAX_CYCLE) begin
      $display("FAIL quadratic_real_roots");
      $finish;
    end
  end

  // present one set, hold until accepted, then idle a random gap
  task automatic send_coeffs(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    start <= 1'b1;
    coeffs <= {a, b, c};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      coeffs <= {$urandom, $urandom, $urandom};
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'(signed'($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return 32'(signed'($urandom_range(0, 200000)) - 100000) <<< 8;
      3: return 32'(signed'($urandom_range(0, 64)) - 32);
      4: return 32'h0;
      default: return 32'(signed'($urandom_range(0, 40)) - 20) <<< 16;
    endcase
  endfunction

  initial begin
    logic [31:0] r0, r1;
    sb = new();
    cycle_count = 0;
    rst = 1'b1;
    start = 1'b0;
    coeffs = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: regular cases, linear, degenerate, overflow, extremes
    send_coeffs(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
    send_coeffs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_coeffs(32'h0001_0000, 32'h0, 32'h0001_0000);
    send_coeffs(32'h0, 32'h0002_0000, 32'hFFFC_0000);
    send_coeffs(32'h0, 32'h0, 32'h1234_5678);
    send_coeffs(32'h0, 32'h0, 32'h0);
    send_coeffs(32'h0, 32'h0000_0001, 32'h7FFF_FFFF);
    send_coeffs(32'h0, 32'hFFFF_FFFF, 32'h8000_0000);
    send_coeffs(32'h0000_0001, 32'h7FFF_FFFF, 32'h0);
    send_coeffs(32'h0000_0001, 32'h0, 32'h8000_0000);
    send_coeffs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coeffs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_coeffs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_coeffs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coeffs(32'h0001_0000, 32'h7FFF_0000, 32'h0);
    send_coeffs(32'h0001_0000, 32'h8000_0000, 32'h0);
    send_coeffs(32'h0000_0100, 32'h0100_0000, 32'hFF00_0000);
    send_coeffs(32'hFFFF_0000, 32'h0003_0000, 32'h0004_0000);
    send_coeffs(32'h0001_0000, 32'h0004_0000, 32'h0004_0000);

    // random coefficient sets
    for (int i = 0; i < N_RANDOM; i++) begin
      r0 = rand_coeff();
      r1 = rand_coeff();
      if ($urandom_range(0, 9) == 0) r0 = 32'h0;
      send_coeffs(r0, r1, rand_coeff());
    end
    start <= 1'b0;

    // drain, then let the pipeline settle
    while (sb.pending_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.n_errors == 0) begin
      $display("PASS quadratic_real_roots");
    end else begin
      $display("FAIL quadratic_real_roots");
    end
    $finish;
  end
endmodule

/* quadratic_real_roots.f */
+incdir+hw/rtl
hw/rtl/qrr_pkg.sv
hw/rtl/qrr_div.sv
hw/rtl/qrr_sqrt.sv
hw/rtl/quadratic_real_roots.sv
tb/quadratic_real_roots_tb.sv
